[hdl/ssd_pkg.sv]
// Shared constants, types and helpers for the SAD stereo disparity block.
// No dependencies; every other file but ssd_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;
	localparam int WIN       = 5;
	localparam int HALF      = WIN / 2;
	localparam int MAX_WIDTH = 1024;
	localparam int MAX_DISP  = 64;
	localparam int DEPTH     = WIN * MAX_WIDTH;
	localparam int AW        = $clog2(DEPTH);
	localparam int KW        = $clog2(WIN);
	localparam int PIX_W     = 8;
	localparam int DISP_W    = 6;
	localparam int COL_W     = 10;
	localparam int ROW_W     = 12;
	localparam int WREG_W    = 11;
	localparam int HREG_W    = 12;
	localparam int RREG_W    = 7;
	localparam int DCNT_W    = $clog2(MAX_DISP + 1);
	localparam int CMP_W     = COL_W + DCNT_W;
	localparam int SAD_W     = $clog2(WIN * WIN * 255 + 1);
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RANGE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_SHIFT, ST_DRAIN, ST_SUM, ST_EVAL, ST_DONE
	} state_t;

	typedef struct packed {
		logic [WREG_W-1:0] width;
		logic [HREG_W-1:0] height;
		logic [DCNT_W-1:0] range;
		logic              restart;
	} cfg_t;

	function automatic logic [AW-1:0] store_addr(input logic [KW-1:0] slot,
		input logic [COL_W-1:0] col);
		logic [AW-1:0] a;
		a = AW'(slot) * AW'(MAX_WIDTH) + AW'(col);
		return a;
	endfunction
endpackage
`default_nettype wire

[hdl/ssd_if.sv]
// Request channels of the disparity block: pixel pairs in, results out.
// Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ssd_pix_if import ssd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] left_pixel;
	logic [PIX_W-1:0] right_pixel;
	modport source(output valid, left_pixel, right_pixel, input ready);
	modport sink(input valid, left_pixel, right_pixel, output ready);
endinterface

interface ssd_res_if import ssd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DISP_W-1:0] disparity;
	logic [COL_W-1:0]  pixel_column;
	logic [ROW_W-1:0]  pixel_row;
	modport source(output valid, disparity, pixel_column, pixel_row, input ready);
	modport sink(input valid, disparity, pixel_column, pixel_row, output ready);
endinterface
`default_nettype wire

[hdl/ssd_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ssd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[hdl/ssd_cfg.sv]
// APB register file for image geometry and disparity range, with clamping.
// Depends on ssd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ssd_cfg import ssd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);
	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;
	logic [RREG_W-1:0] range_q;
	logic [1:0]        idx;
	logic              wr;

	assign pready = 1'b1;
	assign idx    = paddr[PADDR_W-1:2];
	assign wr     = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WREG_W'(640);
			height_q <= HREG_W'(480);
			range_q  <= RREG_W'(64);
		end else if (wr) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[WREG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[HREG_W-1:0];
				REG_RANGE:  range_q  <= pwdata[RREG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_RANGE:  prdata = PDATA_W'(range_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0)
			cfg.width = WREG_W'(1);
		else if (width_q > WREG_W'(MAX_WIDTH))
			cfg.width = WREG_W'(MAX_WIDTH);
		else
			cfg.width = width_q;
		cfg.height = (height_q == '0) ? HREG_W'(1) : height_q;
		if (range_q == '0)
			cfg.range = DCNT_W'(1);
		else if ({1'b0, range_q} > (RREG_W + 1)'(MAX_DISP))
			cfg.range = DCNT_W'(MAX_DISP);
		else
			cfg.range = DCNT_W'(range_q);
		cfg.restart = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);
	end
endmodule
`default_nettype wire

[hdl/stereo_sad_disparity.sv]
// SAD stereo block matcher. Takes one left/right pixel pair per request in raster
// order and returns, for each interior pixel, the lowest disparity with the
// smallest 5x5 sum of absolute differences. The last WIN rows of both images
// live in two RAMs with one read port each. An interior pixel first loads the
// WIN*WIN window, then takes a drain step, WIN column sums and a compare for
// disparity zero; every further level repeats these after WIN right-column reads,
// and a hand-off and accept end the pixel; border pixels only go into the RAMs.
// The read port of the right-image RAM and the column adder set the time per
// pixel. A finished result waits in an output register while the next pixel is
// taken. Depends on ssd_pkg, ssd_if, ssd_ram, ssd_cfg.
`timescale 1ns / 1ps
`default_nettype none
module stereo_sad_disparity import ssd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ssd_pix_if.sink                 pix,
	ssd_res_if.source               res,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);
	typedef struct packed {
		logic          valid;
		logic          left_en;
		logic [KW-1:0] k;
		logic [KW-1:0] i;
	} rd_t;

	cfg_t cfg;

	state_t state_q, state_d;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [KW-1:0]     row_slot_q;
	logic [COL_W-1:0]  lbase_q, rcol_q, cx_q;
	logic [ROW_W-1:0]  cy_q;
	logic [KW-1:0]     slot_q, rslot_q, k_q, i_q, ci_q;
	logic [DCNT_W-1:0] d_q;
	logic [SAD_W-1:0]  acc_q, best_sad_q;
	logic [DISP_W-1:0] best_d_q;
	rd_t               rd_s1;
	logic [PIX_W-1:0]  lwin_q [WIN][WIN];
	logic [PIX_W-1:0]  rwin_q [WIN][WIN];

	logic              outv_q;
	logic [DISP_W-1:0] out_d_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;

	logic              accept, produce, load_last, shift_last, more_d, out_free;
	logic [AW-1:0]     raddr, waddr;
	logic [COL_W-1:0]  rd_col;
	logic [PIX_W-1:0]  l_rdata, r_rdata;
	logic [SAD_W-1:0]  colsum;
	logic [DCNT_W-1:0] dn;
	logic [KW-1:0]     rslot_dec;

	ssd_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid & pix.ready;
	assign produce   = ({1'b0, col_q} < cfg.width) && (row_q < cfg.height)
		&& (col_q >= COL_W'(2 * HALF)) && (row_q >= ROW_W'(2 * HALF));
	assign out_free  = !outv_q || res.ready;

	assign load_last  = (k_q == KW'(WIN - 1)) && (i_q == KW'(WIN - 1));
	assign shift_last = (k_q == KW'(WIN - 1));
	assign dn         = d_q + DCNT_W'(1);
	assign more_d     = (dn < cfg.range)
		&& (CMP_W'(cx_q) >= CMP_W'(dn) + CMP_W'(HALF));
	assign rslot_dec  = (rslot_q == '0) ? KW'(WIN - 1) : rslot_q - KW'(1);

	assign rd_col = (state_q == ST_SHIFT) ? rcol_q : lbase_q + COL_W'(i_q);
	assign raddr  = store_addr(rslot_q, rd_col);
	assign waddr  = store_addr(row_slot_q, col_q);

	ssd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_left_ram (
		.clk, .we(accept), .waddr, .wdata(pix.left_pixel),
		.re(state_q == ST_LOAD), .raddr, .rdata(l_rdata)
	);

	ssd_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_right_ram (
		.clk, .we(accept), .waddr, .wdata(pix.right_pixel),
		.re(state_q == ST_LOAD || state_q == ST_SHIFT), .raddr, .rdata(r_rdata)
	);

	// one window column of absolute differences
	always_comb begin
		colsum = '0;
		for (int k = 0; k < WIN; k++) begin
			if (lwin_q[k][ci_q] > rwin_q[k][ci_q])
				colsum = colsum + SAD_W'(lwin_q[k][ci_q] - rwin_q[k][ci_q]);
			else
				colsum = colsum + SAD_W'(rwin_q[k][ci_q] - lwin_q[k][ci_q]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && produce) state_d = ST_LOAD;
			ST_LOAD:  if (load_last) state_d = ST_DRAIN;
			ST_SHIFT: if (shift_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_SUM;
			ST_SUM:   if (ci_q == KW'(WIN - 1)) state_d = ST_EVAL;
			ST_EVAL:  state_d = more_d ? ST_SHIFT : ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			row_slot_q <= '0;
			rd_s1      <= '0;
			outv_q     <= 1'b0;
		end else begin
			state_q       <= state_d;
			rd_s1.valid   <= (state_q == ST_LOAD) || (state_q == ST_SHIFT);
			rd_s1.left_en <= (state_q == ST_LOAD);
			rd_s1.k       <= k_q;
			rd_s1.i       <= (state_q == ST_LOAD) ? i_q : '0;
			if (cfg.restart) begin
				col_q      <= '0;
				row_q      <= '0;
				row_slot_q <= '0;
			end else if (accept) begin
				if ({1'b0, col_q} + (COL_W + 1)'(1) >= cfg.width) begin
					col_q <= '0;
					if ({1'b0, row_q} + (ROW_W + 1)'(1) >= {1'b0, cfg.height}) begin
						row_q      <= '0;
						row_slot_q <= '0;
					end else begin
						row_q      <= row_q + ROW_W'(1);
						row_slot_q <= (row_slot_q == KW'(WIN - 1)) ? '0
							: row_slot_q + KW'(1);
					end
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (state_q == ST_DONE && out_free)
				outv_q <= 1'b1;
			else if (res.ready)
				outv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1.valid) begin
			rwin_q[rd_s1.k][rd_s1.i] <= r_rdata;
			if (rd_s1.left_en)
				lwin_q[rd_s1.k][rd_s1.i] <= l_rdata;
		end
		case (state_q)
			ST_IDLE: begin
				lbase_q <= col_q - COL_W'(2 * HALF);
				rcol_q  <= col_q - COL_W'(2 * HALF);
				cx_q    <= col_q - COL_W'(HALF);
				cy_q    <= row_q - ROW_W'(HALF);
				slot_q  <= row_slot_q;
				rslot_q <= row_slot_q;
				k_q     <= '0;
				i_q     <= '0;
				d_q     <= '0;
			end
			ST_LOAD: begin
				if (i_q == KW'(WIN - 1)) begin
					i_q     <= '0;
					k_q     <= k_q + KW'(1);
					rslot_q <= rslot_dec;
				end else begin
					i_q <= i_q + KW'(1);
				end
			end
			ST_SHIFT: begin
				k_q     <= k_q + KW'(1);
				rslot_q <= rslot_dec;
			end
			ST_DRAIN: begin
				acc_q <= '0;
				ci_q  <= '0;
			end
			ST_SUM: begin
				acc_q <= acc_q + colsum;
				ci_q  <= ci_q + KW'(1);
			end
			ST_EVAL: begin
				if (d_q == '0 || acc_q < best_sad_q) begin
					best_sad_q <= acc_q;
					best_d_q   <= DISP_W'(d_q);
				end
				// next level: older columns move right, new column enters at 0
				if (more_d) begin
					d_q     <= dn;
					rcol_q  <= rcol_q - COL_W'(1);
					k_q     <= '0;
					rslot_q <= slot_q;
					for (int k = 0; k < WIN; k++) begin
						for (int i = WIN - 1; i > 0; i--) begin
							rwin_q[k][i] <= rwin_q[k][i - 1];
						end
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_d_q   <= best_d_q;
					out_col_q <= cx_q;
					out_row_q <= cy_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid        = outv_q;
	assign res.disparity    = out_d_q;
	assign res.pixel_column = out_col_q;
	assign res.pixel_row    = out_row_q;

`ifndef ASSERT_OFF
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < cfg.width || $past(cfg.restart) || $past(state_q != ST_IDLE))
		else $error("column counter beyond image width");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_slot_q < KW'(WIN))
		else $error("row slot out of range");
	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1.valid |-> $past(state_q == ST_LOAD || state_q == ST_SHIFT))
		else $error("window capture without a read");
	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> DCNT_W'(best_d_q) < cfg.range)
		else $error("winning disparity outside search range");
`endif
endmodule
`default_nettype wire
